/* design/sts_pkg.sv */
// Shared types, constants and elaboration-time table builders for the SOM training step.
// Used by sts_cell, sts_gain_rom and som_training_step; depends on nothing.
package sts_pkg;

    typedef longint          s64_t;
    typedef longint unsigned u64_t;

    localparam int   FRAC      = 48;
    localparam s64_t FX_ONE    = 64'sh0001_0000_0000_0000;
    localparam s64_t FX_PI     = 64'sd884279719003555;
    localparam s64_t FX_TWO_PI = 2 * FX_PI;
    localparam u64_t GAIN_DIV  = 64'd500 << 34;
    localparam u64_t GAIN_HALF = 64'd500 << 33;
    localparam int   ZERO_GAIN = 655;
    localparam int   PHASE_LEN = 1500000;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } neuron_t;

    typedef struct packed {
        logic signed [15:0] sample_x;
        logic signed [15:0] sample_y;
        logic [23:0]        step_count;
    } sample_t;

    typedef struct packed {
        logic [5:0]  winner_index;
        logic [32:0] winner_distance;
    } result_t;

    // shift-and-subtract quotient; table building only
    function automatic u64_t udiv(u64_t a, u64_t b);
        u64_t q;
        u64_t r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--)
        begin
            r = {r[62:0], a[k]};
            if (r >= b)
            begin
                r    = r - b;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // quotient truncated towards zero
    function automatic s64_t sdiv(s64_t a, s64_t b);
        u64_t ua;
        u64_t ub;
        s64_t q;
        ua = (a < 0) ? u64_t'(-a) : u64_t'(a);
        ub = (b < 0) ? u64_t'(-b) : u64_t'(b);
        q  = s64_t'(udiv(ua, ub));
        return ((a < 0) != (b < 0)) ? -q : q;
    endfunction

    // bits [111:48] of the full product
    function automatic u64_t umul_fx(u64_t a, u64_t b);
        logic [127:0] wa;
        logic [127:0] wb;
        logic [127:0] p;
        wa = {64'd0, a};
        wb = {64'd0, b};
        p  = wa * wb;
        return p[111:48];
    endfunction

    function automatic s64_t fmul(s64_t a, s64_t b);
        bit   neg;
        u64_t ua;
        u64_t ub;
        s64_t r;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? u64_t'(-a) : u64_t'(a);
        ub  = (b < 0) ? u64_t'(-b) : u64_t'(b);
        r   = s64_t'(umul_fx(ua, ub));
        return neg ? -r : r;
    endfunction

    function automatic s64_t fx_sin(s64_t x_in);
        s64_t x;
        s64_t x2;
        s64_t term;
        s64_t sum;
        x = x_in;
        while (x > FX_PI)
            x = x - FX_TWO_PI;
        while (x < -FX_PI)
            x = x + FX_TWO_PI;
        x2   = fmul(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n <= 16; n++)
        begin
            term = sdiv(-fmul(term, x2), s64_t'((2 * n) * (2 * n + 1)));
            sum  = sum + term;
        end
        return sum;
    endfunction

    // exp(-f), 0 <= f <= 1
    function automatic s64_t exp_frac(s64_t f);
        s64_t term;
        s64_t sum;
        term = FX_ONE;
        sum  = FX_ONE;
        for (int k = 1; k <= 25; k++)
        begin
            term = sdiv(fmul(term, f), s64_t'(k));
            sum  = ((k & 1) != 0) ? sum - term : sum + term;
        end
        return sum;
    endfunction

    function automatic s64_t exp_neg(s64_t x);
        s64_t n;
        s64_t r;
        s64_t e1;
        n  = x >>> FRAC;
        r  = exp_frac(x & (FX_ONE - 1));
        e1 = exp_frac(FX_ONE);
        for (s64_t i = 0; i < n; i++)
            r = fmul(r, e1);
        return r;
    endfunction

    function automatic int make_gain(int d, int p);
        s64_t c;
        u64_t num;
        u64_t den;
        u64_t q;
        u64_t x;
        u64_t mag;
        u64_t g;
        s64_t t;
        bit   neg;
        if (d == 0)
            return ZERO_GAIN;
        c   = 19 - 10 * s64_t'(p);
        num = 100 * u64_t'(d) * u64_t'(d);
        den = u64_t'(c * c);
        q   = udiv(num, den);
        if (q >= 50)
            return 0;
        x   = (q << FRAC) + udiv((num - q * den) << FRAC, den);
        t   = fmul(fx_sin(s64_t'(d) * FX_ONE), exp_neg(s64_t'(x)));
        neg = (t < 0) != (c < 0);
        mag = (t < 0) ? u64_t'(-t) : u64_t'(t);
        mag = mag * u64_t'(d) * u64_t'((c < 0) ? -c : c);
        g   = udiv(mag + GAIN_HALF, GAIN_DIV);
        if (neg)
            return (g > 32768) ? -32768 : -int'(g);
        return (g > 32767) ? 32767 : int'(g);
    endfunction

    function automatic int round_q(s64_t v);
        u64_t m;
        int   r;
        m = (v < 0) ? u64_t'(-v) : u64_t'(v);
        r = int'((m + (u64_t'(1) << 34)) >> 35);
        return (v < 0) ? -r : r;
    endfunction

    function automatic s64_t init_angle(int i, int n);
        s64_t th;
        th = sdiv(FX_TWO_PI * s64_t'(i), s64_t'(n));
        if (th > FX_PI)
            th = th - FX_TWO_PI;
        return th;
    endfunction

    function automatic int init_x(int i, int n);
        return round_q(fx_sin(init_angle(i, n) + (FX_PI >>> 1)));
    endfunction

    function automatic int init_y(int i, int n);
        return round_q(fx_sin(init_angle(i, n)));
    endfunction

    // n + floor(g*(s-n) / 2^15), saturated
    function automatic logic signed [15:0] move_toward(logic signed [15:0] n,
                                                       logic signed [15:0] s,
                                                       logic signed [15:0] g);
        logic signed [16:0] diff;
        logic signed [32:0] prod;
        logic signed [17:0] sh;
        logic signed [18:0] r;
        diff = 17'(s) - 17'(n);
        prod = 33'(g) * 33'(diff);
        sh   = 18'(prod >>> 15);
        r    = 19'(n) + 19'(sh);
        if (r > 19'sd32767)
            return 16'sh7FFF;
        if (r < -19'sd32768)
            return 16'sh8000;
        return r[15:0];
    endfunction

endpackage

/* design/sts_cell.sv */
// One neuron slot of the rotating ring: holds a position, takes its neighbour's on shift.
// Depends on sts_pkg.
module sts_cell #(
    parameter logic signed [15:0] RESET_X = 16'sd0,
    parameter logic signed [15:0] RESET_Y = 16'sd0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  sts_pkg::neuron_t d,
    output sts_pkg::neuron_t q
);

    sts_pkg::neuron_t pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg.x <= RESET_X;
            pos_reg.y <= RESET_Y;
        end
        else if (shift)
        begin
            pos_reg <= d;
        end
    end

    assign q = pos_reg;

endmodule

/* design/sts_gain_rom.sv */
// Neighbourhood gain ROM (Q1.15), built at elaboration, registered read by phase and distance.
// Depends on sts_pkg.
module sts_gain_rom #(
    parameter int NEURONS = 64,
    parameter int PHASES  = 12,
    parameter int IW      = 6,
    parameter int PW      = 4
) (
    input  logic                  clk,
    input  logic [PW-1:0]         phase,
    input  logic [IW-1:0]         offset,
    output logic signed [15:0]    gain
);

    logic signed [15:0] tab [PHASES][NEURONS];
    logic signed [15:0] gain_reg;

    for (genvar p = 0; p < PHASES; p++)
    begin : g_phase
        for (genvar n = 0; n < NEURONS; n++)
        begin : g_dist
            localparam logic signed [15:0] G = 16'(sts_pkg::make_gain(n, p));
            assign tab[p][n] = G;
        end
    end

    always_ff @(posedge clk)
    begin
        gain_reg <= tab[phase][offset];
    end

    assign gain = gain_reg;

endmodule

/* design/som_training_step.sv */
// SOM training step: NEURONS two-dimensional Q2.14 neurons on a rotating ring of cells.
// Depends on sts_pkg, sts_cell and sts_gain_rom.
//
// For each sample, from transfer to result, the ring rotates once past a squared-distance
// and compare unit to find the winner, then once more past the update unit, one neuron per
// cycle, with a flush state and a gain prefetch state between and a result state after. A
// new sample is taken once the previous update pass has finished and its result has been
// emitted; the result register holds a pending result meanwhile. Reset restores the circle
// of radius 0.5 at once; there is no clearing pass.
module som_training_step #(
    parameter int NEURONS = 64,
    parameter int PHASES  = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  sts_pkg::sample_t  sample,
    output logic              result_valid,
    input  logic              result_stall,
    output sts_pkg::result_t  result
);

    localparam int IW = $clog2(NEURONS);
    localparam int PW = (PHASES > 1) ? $clog2(PHASES) : 1;
    localparam logic [IW-1:0] LAST = IW'(NEURONS - 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_FLUSH  = 6'b000100,
        ST_PREP   = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [IW-1:0]      cnt_reg, cnt_next;
    logic signed [15:0] sx_reg, sy_reg;
    logic [PW-1:0]      phase_reg;
    logic [31:0]        sqx_reg, sqy_reg;
    logic [IW-1:0]      idx_reg;
    logic               pv_reg;
    logic [32:0]        best_reg;
    logic [IW-1:0]      win_reg;
    sts_pkg::result_t   result_reg;
    logic               result_valid_reg;

    sts_pkg::neuron_t   ring [NEURONS];
    sts_pkg::neuron_t   feed;
    sts_pkg::neuron_t   tail;
    logic               shift;

    logic               take;
    logic [PW-1:0]      phase_in;
    logic [IW-1:0]      tail_idx;
    logic signed [16:0] dx, dy;
    logic signed [33:0] px, py;
    logic [32:0]        sq_dist;
    logic [IW-1:0]      rd_idx, rd_dist;
    logic signed [15:0] gain;
    logic               emit;

    assign tail         = ring[NEURONS-1];
    assign sample_stall = (state_reg != ST_IDLE);
    assign take         = sample_valid && !sample_stall;
    assign shift        = (state_reg == ST_SCAN) || (state_reg == ST_UPDATE);
    assign tail_idx     = LAST - cnt_reg;

    always_comb
    begin
        phase_in = '0;
        for (int k = 1; k < PHASES; k++)
        begin
            if ({1'b0, sample.step_count} >= 25'(k * sts_pkg::PHASE_LEN))
                phase_in = phase_in + PW'(1);
        end
    end

    for (genvar i = 0; i < NEURONS; i++)
    begin : g_ring
        localparam logic signed [15:0] RX = 16'(sts_pkg::init_x(i, NEURONS));
        localparam logic signed [15:0] RY = 16'(sts_pkg::init_y(i, NEURONS));
        sts_cell #(
            .RESET_X (RX),
            .RESET_Y (RY)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .d     ((i == 0) ? feed : ring[(i == 0) ? 0 : i - 1]),
            .q     (ring[i])
        );
    end

    always_comb
    begin
        feed = tail;
        if (state_reg == ST_UPDATE)
        begin
            feed.x = sts_pkg::move_toward(tail.x, sx_reg, gain);
            feed.y = sts_pkg::move_toward(tail.y, sy_reg, gain);
        end
    end

    assign dx      = 17'(tail.x) - 17'(sx_reg);
    assign dy      = 17'(tail.y) - 17'(sy_reg);
    assign px      = 34'(dx) * 34'(dx);
    assign py      = 34'(dy) * 34'(dy);
    assign sq_dist = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // gain prefetch: address is for the neuron reaching the tail next cycle
    assign rd_idx  = LAST - cnt_next;
    assign rd_dist = (win_reg > rd_idx) ? (win_reg - rd_idx) : (rd_idx - win_reg);

    sts_gain_rom #(
        .NEURONS (NEURONS),
        .PHASES  (PHASES),
        .IW      (IW),
        .PW      (PW)
    ) u_gain_rom (
        .clk    (clk),
        .phase  (phase_reg),
        .offset (rd_dist),
        .gain   (gain)
    );

    assign emit = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (take)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + IW'(1);
                if (cnt_reg == LAST)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cnt_next   = '0;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cnt_next = cnt_reg + IW'(1);
                if (cnt_reg == LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (emit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            pv_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pv_reg    <= (state_reg == ST_SCAN);
            if (emit)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sx_reg    <= sample.sample_x;
            sy_reg    <= sample.sample_y;
            phase_reg <= phase_in;
        end
        sqx_reg <= px[31:0];
        sqy_reg <= py[31:0];
        idx_reg <= tail_idx;
        // descending scan: <= lets the lower index win ties
        if (pv_reg && ((idx_reg == LAST) || (sq_dist <= best_reg)))
        begin
            best_reg <= sq_dist;
            win_reg  <= idx_reg;
        end
        if (emit)
        begin
            result_reg.winner_index    <= 6'(win_reg);
            result_reg.winner_distance <= best_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
